>>> rtl/mfrpt_pkg.sv
// ----------------------------------------------------------------------------
// mfrpt_pkg
// Shared types and constants of the mesh frame receive block with peer table.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrpt_pkg;

    localparam int PEER_SLOTS = 20;
    localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int KNOWN_W    = $clog2(PEER_SLOTS + 1);

    localparam logic [7:0] MAGIC_ONE     = 8'h42;
    localparam logic [7:0] MAGIC_TWO     = 8'h52;
    localparam logic [7:0] KIND_BEACON   = 8'h01;
    localparam logic [7:0] KIND_DATA     = 8'h02;
    localparam logic [7:0] KIND_DISCOVER = 8'h04;
    localparam logic [7:0] MIN_LENGTH    = 8'd5;

    typedef enum logic [2:0] {
        ACT_SHORT    = 3'd0,
        ACT_FOREIGN  = 3'd1,
        ACT_OWN      = 3'd2,
        ACT_BEACON   = 3'd3,
        ACT_DATA     = 3'd4,
        ACT_RELAY    = 3'd5,
        ACT_DISCOVER = 3'd6,
        ACT_OTHER    = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        PST_FOUND = 2'd0,
        PST_ADDED = 2'd1,
        PST_FULL  = 2'd2,
        PST_NONE  = 2'd3
    } t_peer_status;

    typedef struct packed {
        logic [7:0]  frame_length;
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [7:0]  frame_kind;
        logic [47:0] source_address;
        logic [7:0]  hops_so_far;
        logic [7:0]  time_to_live;
        logic [15:0] sequence_number;
        logic [31:0] time_now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  peer_slot;
        logic [1:0]  peer_status;
        logic [7:0]  relay_hops;
        logic [7:0]  relay_ttl;
        logic [31:0] frames_received;
    } t_out_item;

    // lookup token moving down the cell row
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_token;

    // table update, broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              new_peer;
        logic [SLOT_W-1:0] slot;
        logic [47:0]       addr;
        logic [31:0]       seen;
        logic [15:0]       seq;
    } t_cell_wr;

endpackage

`default_nettype wire

>>> rtl/mfrpt_cell.sv
// ----------------------------------------------------------------------------
// mfrpt_cell
// One peer table entry; compares the passing lookup token and forwards it.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrpt_cell import mfrpt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [SLOT_W-1:0]  i_index,
    input  wire logic [KNOWN_W-1:0] i_known,
    input  wire logic [47:0]        i_key,
    input  wire t_token             i_token,
    output t_token                  o_token,
    input  wire t_cell_wr           i_wr
);

    logic [47:0]       r_addr;
    logic [31:0]       r_seen;
    logic [15:0]       r_seq;
    logic              r_tok_valid;
    logic              r_tok_hit;
    logic [SLOT_W-1:0] r_tok_slot;

    logic in_use;
    logic match;

    assign in_use = KNOWN_W'(i_index) < i_known;
    assign match  = in_use && (r_addr == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_token.valid;
        end
    end

    // first match wins: an earlier hit passes through untouched
    always_ff @(posedge i_clk) begin
        r_tok_hit  <= i_token.hit | match;
        r_tok_slot <= i_token.hit ? i_token.slot : i_index;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == i_index)) begin
            if (i_wr.new_peer) begin
                r_addr <= i_wr.addr;
            end
            r_seen <= i_wr.seen;
            r_seq  <= i_wr.seq;
        end
    end

    assign o_token.valid = r_tok_valid;
    assign o_token.hit   = r_tok_hit;
    assign o_token.slot  = r_tok_slot;

endmodule

`default_nettype wire

>>> rtl/mfrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mfrpt_ctrl
// Frame checks, frame counter, lookup sequencing, table update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrpt_ctrl import mfrpt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [47:0]        i_own_address,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    output t_token                  o_token,
    input  wire t_token             i_token,
    output logic [KNOWN_W-1:0]      o_known,
    output logic [47:0]             o_key,
    output t_cell_wr                o_wr
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic               r_launch;
    logic [KNOWN_W-1:0] r_known, n_known;
    logic [31:0]        r_count, n_count;
    t_out_item          r_result, n_result;
    logic               r_out_valid;
    t_out_item          r_out;

    logic              accept;
    logic              in_good;
    logic              scan_end;
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic              out_load;
    t_action           action;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_good    = (i_in_item.frame_length >= MIN_LENGTH)
                        && (i_in_item.magic_first == MAGIC_ONE)
                        && (i_in_item.magic_second == MAGIC_TWO);

    assign scan_end = (r_state == ST_SCAN) && i_token.valid;
    assign full     = !i_token.hit && (r_known == KNOWN_W'(PEER_SLOTS));
    assign slot     = i_token.hit ? i_token.slot : r_known[SLOT_W-1:0];
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_item.source_address == i_own_address) begin
            action = ACT_OWN;
        end else begin
            case (r_item.frame_kind)
                KIND_BEACON:   action = ACT_BEACON;
                KIND_DATA:     action = (r_item.time_to_live != 8'd0) ? ACT_RELAY : ACT_DATA;
                KIND_DISCOVER: action = ACT_DISCOVER;
                default:       action = ACT_OTHER;
            endcase
        end
    end

    always_comb begin
        o_wr.en       = scan_end && !full;
        o_wr.new_peer = !i_token.hit;
        o_wr.slot     = slot;
        o_wr.addr     = r_item.source_address;
        o_wr.seen     = r_item.time_now_ms;
        o_wr.seq      = r_item.sequence_number;
    end

    always_comb begin
        n_state  = r_state;
        n_known  = r_known;
        n_count  = r_count;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_result.peer_slot   = 5'd0;
                    n_result.peer_status = PST_NONE;
                    n_result.relay_hops  = 8'd0;
                    n_result.relay_ttl   = 8'd0;
                    if (in_good) begin
                        n_count = r_count + 32'd1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                        n_result.action = (i_in_item.frame_length < MIN_LENGTH)
                                          ? ACT_SHORT : ACT_FOREIGN;
                    end
                    n_result.frames_received = n_count;
                end
            end
            ST_SCAN: begin
                if (i_token.valid) begin
                    n_state         = ST_DONE;
                    n_result.action = action;
                    if (i_token.hit) begin
                        n_result.peer_status = PST_FOUND;
                    end else if (full) begin
                        n_result.peer_status = PST_FULL;
                    end else begin
                        n_result.peer_status = PST_ADDED;
                        n_known = r_known + KNOWN_W'(1);
                    end
                    n_result.peer_slot = full ? 5'd0 : 5'(slot);
                    if (action == ACT_RELAY) begin
                        n_result.relay_hops = r_item.hops_so_far + 8'd1;
                        n_result.relay_ttl  = r_item.time_to_live - 8'd1;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_known     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept && in_good;
            r_known  <= n_known;
            r_count  <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        r_result <= n_result;
        if (out_load) begin
            r_out <= r_result;
        end
    end

    // token enters the row the cycle after the item is captured
    assign o_token.valid = r_launch;
    assign o_token.hit   = 1'b0;
    assign o_token.slot  = '0;
    assign o_known       = r_known;
    assign o_key         = r_item.source_address;
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out;

    a_known_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known <= KNOWN_W'(PEER_SLOTS))
        else $error("peer count beyond table size");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_token.valid |-> (r_state == ST_SCAN))
        else $error("lookup token outside of a scan");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.en && o_wr.new_peer) |=> (r_known == $past(r_known) + KNOWN_W'(1)))
        else $error("append did not bump peer count");

    a_relay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.action != ACT_RELAY))
        |-> ((o_out_item.relay_hops == 8'd0) && (o_out_item.relay_ttl == 8'd0)))
        else $error("relay fields set on non-relay item");

    a_no_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.peer_status == PST_NONE))
        |-> ((o_out_item.action == ACT_SHORT) || (o_out_item.action == ACT_FOREIGN)))
        else $error("accepted frame reported without lookup");

endmodule

`default_nettype wire

>>> rtl/mesh_frame_receive_peer_table.sv
// ----------------------------------------------------------------------------
// mesh_frame_receive_peer_table
// Mesh frame header receive path with a peer table held in a row of cells.
// ----------------------------------------------------------------------------
// One frame header is taken at a time. A short or foreign frame skips the
// lookup; its result passes through the done state into the output
// register, and the next item is accepted after that. Other frames send a
// lookup token down the row of PEER_SLOTS table cells, one cell per cycle,
// and the result is formed when the token leaves the last cell; the length
// of the cell row sets how long a lookup takes. The result sits in an
// output register, so a new item is accepted while the previous result
// waits to be taken; the block stalls only when the next result is ready
// before that one is taken. Table entries are only compared below the
// peer count, which reset clears.
`default_nettype none

module mesh_frame_receive_peer_table import mfrpt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [47:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item
);

    logic [47:0]        r_own_address;
    t_token             w_tok [PEER_SLOTS+1];
    logic [KNOWN_W-1:0] w_known;
    logic [47:0]        w_key;
    t_cell_wr           w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (i_cfg_wr_en) begin
            r_own_address <= i_cfg_wr_data;
        end
    end

    mfrpt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_address (r_own_address),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item),
        .o_token       (w_tok[0]),
        .i_token       (w_tok[PEER_SLOTS]),
        .o_known       (w_known),
        .o_key         (w_key),
        .o_wr          (w_wr)
    );

    for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
        mfrpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLOT_W'(g)),
            .i_known (w_known),
            .i_key   (w_key),
            .i_token (w_tok[g]),
            .o_token (w_tok[g+1]),
            .i_wr    (w_wr)
        );
    end

endmodule

`default_nettype wire

>>> test/mesh_frame_receive_peer_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_frame_receive_peer_table_test
// Self-checking bench for the mesh frame receive block with its peer table.
// ----------------------------------------------------------------------------
// A short table of hand-made headers covers short, foreign, own and every
// frame kind, plus the relay wrap cases. Random phases follow, each with its
// own station address. Most frames are well formed and come from a small
// address pool, so the table fills up and then reports full. Every result is
// checked against an in-bench model of the counter and the peer table, or a
// typed row against its hand-made result. Both handshakes see random gaps.

module mesh_frame_receive_peer_table_test;
    import mfrpt_pkg::*;

    localparam int POOL_SIZE       = 26;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 266;
    localparam int DRAIN_SLACK     = 30;
    localparam int PRINT_CAP       = 200;

    localparam logic [47:0] OWN_A     = 48'h0123_4567_89AB;
    localparam logic [47:0] PEER_A    = 48'hA1A1_0000_0001;
    localparam logic [47:0] PEER_B    = 48'h8000_0000_0002;
    localparam logic [47:0] PEER_C    = 48'h0000_5A5A_0003;
    localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        t_in_item  frame;
        logic      typed;
        t_out_item result;
    } t_frame_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [47:0] cfg_wr_data;
    logic        in_valid;
    t_in_item    in_item;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_item;

    // model of the block
    logic [47:0] own_addr_mdl;
    logic [47:0] peer_addr_mdl [PEER_SLOTS];
    logic [31:0] peer_seen_mdl [PEER_SLOTS];
    logic [15:0] peer_seq_mdl  [PEER_SLOTS];
    int          peers_known_mdl;
    logic [31:0] frames_accepted;

    t_out_item   pending_results [$];
    t_frame_row  directed_rows [$];
    logic [47:0] addr_pool [POOL_SIZE];
    int          mismatches;
    int          results_checked;
    t_out_item   want;

    mesh_frame_receive_peer_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_item    (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_in_item mk_frame(logic [7:0] len, logic [7:0] m1, logic [7:0] m2,
                                          logic [7:0] kind, logic [47:0] src,
                                          logic [7:0] hops, logic [7:0] ttl,
                                          logic [15:0] seq, logic [31:0] now);
        t_in_item f;
        f.frame_length    = len;
        f.magic_first     = m1;
        f.magic_second    = m2;
        f.frame_kind      = kind;
        f.source_address  = src;
        f.hops_so_far     = hops;
        f.time_to_live    = ttl;
        f.sequence_number = seq;
        f.time_now_ms     = now;
        return f;
    endfunction

    function automatic t_out_item mk_result(t_action act, int slot, t_peer_status st,
                                            logic [7:0] rhops, logic [7:0] rttl,
                                            logic [31:0] count);
        t_out_item r;
        r.action          = act;
        r.peer_slot       = 5'(slot);
        r.peer_status     = st;
        r.relay_hops      = rhops;
        r.relay_ttl       = rttl;
        r.frames_received = count;
        return r;
    endfunction

    // Works out the result of one accepted header and advances the table.
    function automatic t_out_item predict_receive(t_in_item f);
        t_out_item r;
        int        idx;
        logic      hit;
        r             = '0;
        r.peer_status = PST_NONE;
        hit           = 1'b0;
        if (f.frame_length < MIN_LENGTH) begin
            r.action = ACT_SHORT;
        end else if (f.magic_first != MAGIC_ONE || f.magic_second != MAGIC_TWO) begin
            r.action = ACT_FOREIGN;
        end else begin
            frames_accepted = frames_accepted + 32'd1;
            for (idx = 0; idx < peers_known_mdl; idx++) begin
                if (!hit && peer_addr_mdl[idx] == f.source_address) begin
                    hit         = 1'b1;
                    r.peer_slot = 5'(idx);
                end
            end
            if (hit) begin
                r.peer_status = PST_FOUND;
            end else if (peers_known_mdl < PEER_SLOTS) begin
                r.peer_slot                    = 5'(peers_known_mdl);
                peer_addr_mdl[peers_known_mdl] = f.source_address;
                peers_known_mdl++;
                r.peer_status = PST_ADDED;
                hit           = 1'b1;
            end else begin
                r.peer_status = PST_FULL;
            end
            if (hit) begin
                peer_seen_mdl[r.peer_slot] = f.time_now_ms;
                peer_seq_mdl[r.peer_slot]  = f.sequence_number;
            end
            if (f.source_address == own_addr_mdl) begin
                r.action = ACT_OWN;
            end else if (f.frame_kind == KIND_BEACON) begin
                r.action = ACT_BEACON;
            end else if (f.frame_kind == KIND_DATA) begin
                if (f.time_to_live != 8'd0) begin
                    r.action     = ACT_RELAY;
                    r.relay_hops = f.hops_so_far + 8'd1;
                    r.relay_ttl  = f.time_to_live - 8'd1;
                end else begin
                    r.action = ACT_DATA;
                end
            end else if (f.frame_kind == KIND_DISCOVER) begin
                r.action = ACT_DISCOVER;
            end else begin
                r.action = ACT_OTHER;
            end
        end
        r.frames_received = frames_accepted;
        return r;
    endfunction

    task automatic add_row(t_in_item f, logic typed, t_out_item r);
        t_frame_row row;
        row.frame  = f;
        row.typed  = typed;
        row.result = r;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        mismatches++;
        // keep the log short on a badly broken block
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH result %0d %s: got %0h, want %0h",
                     results_checked, what, got, exp_val);
    endtask

    // Random header: mostly well formed, from the address pool.
    task automatic random_frame(output t_in_item f);
        int r;
        r = $urandom_range(99);
        f.frame_length = (r < 8) ? 8'($urandom_range(4)) : 8'($urandom_range(255, 5));
        r = $urandom_range(99);
        if (r < 5) begin
            f.magic_first  = 8'($urandom);
            f.magic_second = 8'($urandom);
        end else if (r < 8) begin
            f.magic_first  = 8'($urandom);
            f.magic_second = MAGIC_TWO;
        end else if (r < 11) begin
            f.magic_first  = MAGIC_ONE;
            f.magic_second = 8'($urandom);
        end else begin
            f.magic_first  = MAGIC_ONE;
            f.magic_second = MAGIC_TWO;
        end
        r = $urandom_range(99);
        if (r < 28)      f.frame_kind = KIND_BEACON;
        else if (r < 60) f.frame_kind = KIND_DATA;
        else if (r < 85) f.frame_kind = KIND_DISCOVER;
        else             f.frame_kind = 8'($urandom);
        r = $urandom_range(99);
        if (r < 65)      f.source_address = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 75) f.source_address = own_addr_mdl;
        else             f.source_address = {16'($urandom), 32'($urandom)};
        f.hops_so_far = 8'($urandom);
        r = $urandom_range(99);
        if (r < 15)      f.time_to_live = 8'd0;
        else if (r < 22) f.time_to_live = 8'hFF;
        else             f.time_to_live = 8'($urandom);
        f.sequence_number = 16'($urandom);
        f.time_now_ms     = 32'($urandom);
    endtask

    // Presents one item after a random gap and files its expected result.
    task automatic send_frame(t_in_item f, logic typed, t_out_item typed_result);
        int        r;
        int        gap;
        t_out_item predicted;
        @(negedge i_clk);
        r = $urandom_range(99);
        if (r < 50)      gap = 0;
        else if (r < 85) gap = $urandom_range(4, 1);
        else if (r < 97) gap = $urandom_range(24, 5);
        else             gap = $urandom_range(80, 30);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= f;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = predict_receive(f);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Stops sending and waits until the block has delivered everything.
    task automatic wait_for_drain;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic write_own_address(logic [47:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en    <= 1'b0;
        own_addr_mdl  = value;
        @(negedge i_clk);
    endtask

    // result side: random stalls, with occasional long stretches of ready
    initial begin
        int r;
        int hold;
        int run;
        @(negedge i_clk);
        forever begin
            r = $urandom_range(99);
            if (r < 55)      hold = 0;
            else if (r < 90) hold = $urandom_range(3, 1);
            else             hold = $urandom_range(40, 8);
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            r   = $urandom_range(99);
            run = (r < 85) ? $urandom_range(6, 1) : $urandom_range(150, 40);
            repeat (run) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_item), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_item.action !== want.action)
                    report_mismatch("action", 64'(out_item.action), 64'(want.action));
                if (out_item.peer_slot !== want.peer_slot)
                    report_mismatch("peer_slot", 64'(out_item.peer_slot), 64'(want.peer_slot));
                if (out_item.peer_status !== want.peer_status)
                    report_mismatch("peer_status", 64'(out_item.peer_status),
                                    64'(want.peer_status));
                if (out_item.relay_hops !== want.relay_hops)
                    report_mismatch("relay_hops", 64'(out_item.relay_hops),
                                    64'(want.relay_hops));
                if (out_item.relay_ttl !== want.relay_ttl)
                    report_mismatch("relay_ttl", 64'(out_item.relay_ttl), 64'(want.relay_ttl));
                if (out_item.frames_received !== want.frames_received)
                    report_mismatch("frames_received", 64'(out_item.frames_received),
                                    64'(want.frames_received));
            end
            results_checked++;
        end
    end

    initial begin
        t_in_item    f;
        t_frame_row  row;
        int          phase;
        int          n;
        logic [47:0] own_pick;

        i_rst_n         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        in_item         = '0;
        own_addr_mdl    = '0;
        peers_known_mdl = 0;
        frames_accepted = '0;
        mismatches      = 0;
        results_checked = 0;
        for (n = 0; n < POOL_SIZE; n++)
            addr_pool[n] = {16'($urandom), 32'($urandom)};

        // directed rows, own address is OWN_A
        add_row(mk_frame(8'd0, MAGIC_ONE, MAGIC_TWO, KIND_BEACON, PEER_A, 0, 0, 0, 0),
                1'b1, mk_result(ACT_SHORT, 0, PST_NONE, 0, 0, 0));
        add_row(mk_frame(8'd4, MAGIC_ONE, MAGIC_TWO, KIND_DATA, PEER_A, 3, 5, 1, 10),
                1'b1, mk_result(ACT_SHORT, 0, PST_NONE, 0, 0, 0));
        add_row(mk_frame(8'd5, 8'h43, MAGIC_TWO, KIND_BEACON, PEER_A, 0, 0, 2, 20),
                1'b1, mk_result(ACT_FOREIGN, 0, PST_NONE, 0, 0, 0));
        add_row(mk_frame(8'hFF, MAGIC_ONE, 8'h53, KIND_DATA, PEER_A, 1, 1, 3, 30),
                1'b1, mk_result(ACT_FOREIGN, 0, PST_NONE, 0, 0, 0));
        add_row(mk_frame(8'd5, MAGIC_ONE, MAGIC_TWO, KIND_BEACON, PEER_A, 0, 0, 0, 0),
                1'b1, mk_result(ACT_BEACON, 0, PST_ADDED, 0, 0, 1));
        add_row(mk_frame(8'hFF, MAGIC_ONE, MAGIC_TWO, KIND_DATA, PEER_A, 7, 0, 5, 50),
                1'b1, mk_result(ACT_DATA, 0, PST_FOUND, 0, 0, 2));
        add_row(mk_frame(8'd20, MAGIC_ONE, MAGIC_TWO, KIND_DATA, PEER_B, 8'hFF, 8'hFF, 6, 60),
                1'b1, mk_result(ACT_RELAY, 1, PST_ADDED, 8'd0, 8'd254, 3));
        add_row(mk_frame(8'd20, MAGIC_ONE, MAGIC_TWO, KIND_DATA, PEER_B, 0, 1, 7, 70),
                1'b1, mk_result(ACT_RELAY, 1, PST_FOUND, 8'd1, 8'd0, 4));
        add_row(mk_frame(8'd9, MAGIC_ONE, MAGIC_TWO, KIND_DISCOVER, PEER_C, 2, 2, 8, 80),
                1'b1, mk_result(ACT_DISCOVER, 2, PST_ADDED, 0, 0, 5));
        add_row(mk_frame(8'd9, MAGIC_ONE, MAGIC_TWO, KIND_DATA, OWN_A, 4, 9, 9, 90),
                1'b1, mk_result(ACT_OWN, 3, PST_ADDED, 0, 0, 6));
        add_row(mk_frame(8'd9, MAGIC_ONE, MAGIC_TWO, KIND_BEACON, OWN_A, 4, 9, 10, 91),
                1'b1, mk_result(ACT_OWN, 3, PST_FOUND, 0, 0, 7));
        add_row(mk_frame(8'd6, MAGIC_ONE, MAGIC_TWO, 8'h00, PEER_A, 1, 1, 11, 100),
                1'b0, '0);
        add_row(mk_frame(8'hFF, MAGIC_ONE, MAGIC_TWO, 8'hFF, ADDR_ONES, 8'hFF, 8'hFF,
                         16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_frame(8'd7, MAGIC_ONE, MAGIC_TWO, 8'h03, 48'd0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(8'd7, MAGIC_ONE, MAGIC_TWO, 8'h08, PEER_C, 5, 5, 12, 110),
                1'b0, '0);
        // beacon bit with high bits set is not a beacon
        add_row(mk_frame(8'd7, MAGIC_ONE, MAGIC_TWO, 8'h81, PEER_B, 5, 5, 13, 120),
                1'b0, '0);
        add_row(mk_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, ADDR_ONES, 8'hFF, 8'hFF, 16'hFFFF,
                         32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_frame(8'd4, 8'hFF, 8'hFF, 8'hFF, ADDR_ONES, 8'hFF, 8'hFF, 16'hFFFF,
                         32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_frame(8'd5, MAGIC_ONE, MAGIC_TWO, KIND_DATA, ADDR_ONES, 8'hFF, 8'd0,
                         14, 130), 1'b0, '0);
        add_row(mk_frame(8'd5, MAGIC_ONE, MAGIC_TWO, KIND_DISCOVER, 48'd0, 0, 0, 15, 140),
                1'b0, '0);
        add_row(mk_frame(8'd5, MAGIC_ONE, 8'h00, KIND_BEACON, PEER_A, 0, 0, 16, 150),
                1'b0, '0);
        add_row(mk_frame(8'd5, 8'h00, MAGIC_TWO, KIND_BEACON, PEER_A, 0, 0, 17, 160),
                1'b0, '0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_own_address(OWN_A);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_frame(row.frame, row.typed, row.result);
        end
        wait_for_drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       own_pick = '0;
                1:       own_pick = ADDR_ONES;
                2:       own_pick = addr_pool[2];
                3:       own_pick = {16'($urandom), 32'($urandom)};
                default: own_pick = addr_pool[5];
            endcase
            write_own_address(own_pick);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_frame(f);
                send_frame(f, 1'b0, '0);
            end
            // every phase ends with the sender held off until all results are in
            wait_for_drain();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
